FILE: sv/kmcu_pkg.sv
`timescale 1ns / 1ps

package kmcu_pkg;

  localparam int NUM_DIMS_DEF     = 16;
  localparam int MAX_CLUSTERS_DEF = 16;

  localparam int CNT_W  = 24;
  localparam int DATA_W = 32;
  localparam int ACC_W  = 64;
  localparam int ACT_W  = 5;
  // signed numerator width of the running-mean update: 32x25 product plus one
  localparam int DIV_W  = 58;

  localparam logic [CNT_W-1:0]  COUNT_FULL   = {CNT_W{1'b1}};
  localparam logic [ACT_W-1:0]  ACTIVE_RESET = ACT_W'(16);

  typedef enum logic [1:0] {
    MODE_FIND   = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_F_RD,
    S_F_SQ,
    S_F_ACC,
    S_MIN_INIT,
    S_MIN,
    S_RD,
    S_CHK,
    S_MUL,
    S_DIV_SET,
    S_DIV,
    S_WB,
    S_OUT
  } state_t;

endpackage

FILE: sv/kmeans_centroid_update_and_assign.sv
`timescale 1ns / 1ps
// per beat: read via S_RD; a find element walks all clusters (S_F_RD, S_F_SQ, S_F_ACC),
//   the last adds the minimum scan; add/remove runs S_CHK to S_WB, the last element twice
// throughput: one beat at a time, set by the single-port centroid memory walk (find)
//   and the one-bit-per-cycle restoring divider (add/remove); a waiting result holds input
// reset: rst_n synchronous active low; counts, means and distances clear at once, then the
//   centroid memory is swept to zero entry by entry in S_CLR, and no beat is taken meanwhile
module kmeans_centroid_update_and_assign
  import kmcu_pkg::*;
#(
  parameter int NUM_DIMS     = NUM_DIMS_DEF,
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: active_clusters
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // cluster_index[3:0], element_index[7:4], feature_value[39:8], attribute_value[71:40]
  input  logic [71:0] in_tdata,
  // mode[1:0]
  input  logic [1:0]  in_tuser,
  // last_element
  input  logic        in_tlast,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // nearest_cluster[3:0], member_total[27:4], centroid_element[59:28],
  // mean_attribute_out[91:60], op_status[93:92], zero pad[95:94]
  output logic [95:0] out_tdata
);

  localparam int STORE_DEPTH = MAX_CLUSTERS * NUM_DIMS;
  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int KW  = $clog2(MAX_CLUSTERS);
  localparam int KCW = KW + 1;
  localparam int DCW = $clog2(DIV_W);

  // centroid memory, registered read
  logic signed [DATA_W-1:0] mem [STORE_DEPTH];
  logic signed [DATA_W-1:0] mem_rdata_r;
  logic [AW-1:0]            mem_addr;
  logic                     mem_we;
  logic signed [DATA_W-1:0] mem_wdata;

  // per-cluster state
  logic [CNT_W-1:0]         cnt_r  [MAX_CLUSTERS];
  logic signed [DATA_W-1:0] mean_r [MAX_CLUSTERS];
  logic [ACC_W-1:0]         acc_r  [MAX_CLUSTERS];

  state_t state_r, state_nxt;
  logic [ACT_W-1:0] act_r;
  logic [AW-1:0]    clr_addr_r;

  // captured beat
  mode_t                    mode_r;
  logic [3:0]               cl_r;
  logic [3:0]               el_r;
  logic signed [DATA_W-1:0] fv_r;
  logic signed [DATA_W-1:0] av_r;
  logic                     last_r;
  logic                     el_ok_r;
  logic                     cl_ok_r;
  status_t                  st_r;

  logic [KCW-1:0]           k_r;
  logic [KW-1:0]            best_r;
  logic [ACC_W-1:0]         bval_r;
  logic [ACC_W-1:0]         sq_r;

  // running-mean datapath
  logic                     at_r;     // 0 element update, 1 attribute/count update
  logic [CNT_W-1:0]         n_r;
  logic signed [DIV_W-2:0]  prod_r;
  logic [DIV_W-1:0]         q_r;
  logic [CNT_W+1:0]         rem_r;
  logic [CNT_W:0]           den_r;
  logic                     neg_r;
  logic [DCW-1:0]           dcnt_r;

  logic                     out_valid_r;
  logic [95:0]              out_data_r;

  // input decode
  logic [3:0]               in_cl;
  logic [3:0]               in_el;
  logic                     in_el_ok;
  logic                     in_cl_ok;
  logic                     in_acc;

  assign in_cl    = in_tdata[3:0];
  assign in_el    = in_tdata[7:4];
  assign in_el_ok = int'(in_el) < NUM_DIMS;
  assign in_cl_ok = int'(in_cl) < MAX_CLUSTERS;
  assign in_acc   = in_tvalid && in_tready;

  // cluster selection for count/mean reads and writes
  logic [KW-1:0]            sel;
  logic [CNT_W-1:0]         cnt_sel;
  logic signed [DATA_W-1:0] mean_sel;
  assign sel      = (mode_r == MODE_FIND) ? best_r : KW'(cl_r);
  assign cnt_sel  = cnt_r[sel];
  assign mean_sel = mean_r[sel];

  // effective number of searched clusters
  logic [KCW-1:0] n_eff;
  always_comb begin
    if (act_r == '0)                      n_eff = KCW'(1);
    else if (int'(act_r) > MAX_CLUSTERS)  n_eff = KCW'(MAX_CLUSTERS);
    else                                  n_eff = KCW'(act_r);
  end

  // memory address: clear sweep in S_CLR, walk clusters in find, target entry otherwise
  always_comb begin
    if (state_r == S_CLR)
      mem_addr = clr_addr_r;
    else if (mode_r == MODE_FIND)
      mem_addr = AW'(int'(k_r[KW-1:0]) * NUM_DIMS + int'(el_r));
    else
      mem_addr = AW'(int'(cl_r) * NUM_DIMS + int'(el_r));
  end

  // distance term and saturating accumulate
  logic signed [DATA_W:0] diff;
  logic [DATA_W-1:0]      mag;
  logic [ACC_W-1:0]       acc_base;
  logic [ACC_W:0]         acc_sum;
  logic [ACC_W-1:0]       acc_new;
  assign diff     = {fv_r[DATA_W-1], fv_r} - {mem_rdata_r[DATA_W-1], mem_rdata_r};
  assign mag      = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
  assign acc_base = (el_r == '0) ? '0 : acc_r[k_r[KW-1:0]];
  assign acc_sum  = {1'b0, acc_base} + {1'b0, sq_r};
  assign acc_new  = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];

  // running mean: operands, numerator, divider step, saturation
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_x;
  logic signed [DIV_W-1:0]  num;
  logic                     rem_one;
  logic [CNT_W+1:0]         div_t;
  logic                     div_bit;
  logic signed [DIV_W:0]    q_s;
  logic signed [DATA_W-1:0] q_sat;
  assign mul_a   = at_r ? mean_sel : mem_rdata_r;
  assign mul_x   = at_r ? av_r : fv_r;
  assign num     = (mode_r == MODE_ADD)
                 ? {prod_r[DIV_W-2], prod_r} + DIV_W'(mul_x)
                 : {prod_r[DIV_W-2], prod_r} - DIV_W'(mul_x);
  assign rem_one = (mode_r == MODE_REMOVE) && (n_r == CNT_W'(1));
  assign div_t   = {rem_r[CNT_W:0], q_r[DIV_W-1]};
  assign div_bit = div_t >= {1'b0, den_r};
  assign q_s     = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  always_comb begin
    if (q_s > $signed((DIV_W+1)'(32'sh7fffffff)))
      q_sat = 32'sh7fffffff;
    else if (q_s < -$signed((DIV_W+1)'(33'sh080000000)))
      q_sat = 32'sh80000000;
    else
      q_sat = q_s[DATA_W-1:0];
  end

  // status of an add/remove from the current count
  status_t chk_st;
  always_comb begin
    if (mode_r == MODE_ADD && cnt_sel == COUNT_FULL)       chk_st = ST_FULL;
    else if (mode_r == MODE_REMOVE && cnt_sel == '0)      chk_st = ST_EMPTY;
    else if (el_ok_r)                                     chk_st = ST_OK;
    else                                                  chk_st = ST_RANGE;
  end

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        if (clr_addr_r == AW'(STORE_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (mode_t'(in_tuser))
            MODE_FIND: begin
              if (in_el_ok)     state_nxt = S_F_RD;
              else if (in_tlast) state_nxt = S_MIN_INIT;
            end
            MODE_READ: state_nxt = in_cl_ok ? S_RD : S_OUT;
            default: begin
              if (in_cl_ok)      state_nxt = S_CHK;
              else if (in_tlast) state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_F_RD:  state_nxt = S_F_SQ;
      S_F_SQ:  state_nxt = S_F_ACC;
      S_F_ACC: begin
        if (k_r == KCW'(MAX_CLUSTERS - 1)) state_nxt = last_r ? S_MIN_INIT : S_IDLE;
        else                               state_nxt = S_F_RD;
      end
      S_MIN_INIT: state_nxt = S_MIN;
      S_MIN: begin
        if (k_r >= n_eff) state_nxt = S_OUT;
      end
      S_RD: state_nxt = S_OUT;
      S_CHK: begin
        if (chk_st == ST_OK)                    state_nxt = S_MUL;
        else if (last_r && chk_st == ST_RANGE)  state_nxt = S_MUL;
        else if (last_r)                        state_nxt = S_OUT;
        else                                    state_nxt = S_IDLE;
      end
      S_MUL: begin
        if (rem_one) begin
          if (at_r)        state_nxt = S_OUT;
          else if (last_r) state_nxt = S_MUL;
          else             state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DIV_SET;
        end
      end
      S_DIV_SET: state_nxt = S_DIV;
      S_DIV: begin
        if (dcnt_r == DCW'(DIV_W - 1)) state_nxt = S_WB;
      end
      S_WB: begin
        if (at_r)        state_nxt = S_OUT;
        else if (last_r) state_nxt = S_MUL;
        else             state_nxt = S_IDLE;
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = '0;
    unique case (state_r)
      S_CLR:  mem_we = 1'b1;
      S_IDLE: in_tready = 1'b1;
      S_MUL: begin
        if (rem_one && !at_r) mem_we = 1'b1;
      end
      S_WB: begin
        if (!at_r) begin
          mem_we    = 1'b1;
          mem_wdata = q_sat;
        end
      end
      default: ;
    endcase
  end

  // result composition
  logic [3:0]               res_cl;
  logic [CNT_W-1:0]         res_cnt;
  logic signed [DATA_W-1:0] res_elem;
  logic signed [DATA_W-1:0] res_mean;
  status_t                  res_st;
  always_comb begin
    res_cl   = cl_r;
    res_cnt  = '0;
    res_elem = '0;
    res_mean = '0;
    res_st   = ST_RANGE;
    if (mode_r == MODE_FIND) begin
      res_cl   = 4'(best_r);
      res_cnt  = cnt_sel;
      res_mean = mean_sel;
      res_st   = st_r;
    end else if (cl_ok_r) begin
      res_cnt  = cnt_sel;
      res_mean = mean_sel;
      res_st   = st_r;
      if (mode_r == MODE_READ && el_ok_r) res_elem = mem_rdata_r;
    end
  end

  // centroid memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata_r <= mem[mem_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      act_r       <= ACTIVE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_addr_r <= clr_addr_r + AW'(1);
      if (cfg_we) act_r <= cfg_wdata;
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_tready)              out_valid_r <= 1'b0;
    end
  end

  // per-cluster state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        cnt_r[i]  <= '0;
        mean_r[i] <= '0;
        acc_r[i]  <= '0;
      end
    end else begin
      if (state_r == S_F_ACC) acc_r[k_r[KW-1:0]] <= acc_new;
      if (state_r == S_MUL && rem_one && at_r) begin
        mean_r[sel] <= '0;
        cnt_r[sel]  <= '0;
      end
      if (state_r == S_WB && at_r) begin
        mean_r[sel] <= q_sat;
        cnt_r[sel]  <= (mode_r == MODE_ADD) ? cnt_sel + CNT_W'(1) : cnt_sel - CNT_W'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_r  <= mode_t'(in_tuser);
          cl_r    <= in_cl;
          el_r    <= in_el;
          fv_r    <= in_tdata[39:8];
          av_r    <= in_tdata[71:40];
          last_r  <= in_tlast;
          el_ok_r <= in_el_ok;
          cl_ok_r <= in_cl_ok;
          st_r    <= in_el_ok ? ST_OK : ST_RANGE;
          k_r     <= '0;
          at_r    <= 1'b0;
        end
      end
      S_F_SQ:  sq_r <= ACC_W'(mag) * ACC_W'(mag);
      S_F_ACC: k_r <= k_r + KCW'(1);
      S_MIN_INIT: begin
        best_r <= '0;
        bval_r <= acc_r[0];
        k_r    <= KCW'(1);
      end
      S_MIN: begin
        if (k_r < n_eff) begin
          if (acc_r[k_r[KW-1:0]] < bval_r) begin
            best_r <= k_r[KW-1:0];
            bval_r <= acc_r[k_r[KW-1:0]];
          end
          k_r <= k_r + KCW'(1);
        end
      end
      S_CHK: begin
        st_r <= chk_st;
        n_r  <= cnt_sel;
        if (chk_st == ST_RANGE) at_r <= 1'b1;
      end
      S_MUL: begin
        prod_r <= (DIV_W-1)'(mul_a) * (DIV_W-1)'($signed({1'b0, n_r}));
        if (rem_one && !at_r) at_r <= 1'b1;
      end
      S_DIV_SET: begin
        neg_r  <= num[DIV_W-1];
        q_r    <= num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
        rem_r  <= '0;
        dcnt_r <= '0;
        den_r  <= (mode_r == MODE_ADD) ? {1'b0, n_r} + (CNT_W+1)'(1)
                                       : {1'b0, n_r} - (CNT_W+1)'(1);
      end
      S_DIV: begin
        rem_r  <= div_bit ? div_t - {1'b0, den_r} : div_t;
        q_r    <= {q_r[DIV_W-2:0], div_bit};
        dcnt_r <= dcnt_r + DCW'(1);
      end
      S_WB: begin
        if (!at_r) at_r <= 1'b1;
      end
      S_OUT: begin
        if (out_free)
          out_data_r <= {2'b00, res_st, res_mean, res_elem, res_cnt, res_cl};
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !in_tready)
    else $error("beat accepted during memory clear");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLR || state_r == S_MUL || state_r == S_WB))
    else $error("centroid write outside update states");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && dcnt_r == DCW'(DIV_W - 1) |=> state_r == S_WB)
    else $error("divider did not finish");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_F_ACC |-> k_r < KCW'(MAX_CLUSTERS))
    else $error("cluster walk out of range");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("result not presented");

endmodule
